/* src/sop_pkg.sv */
// shared constants and codes for the spiral order position block
// no dependencies
`default_nettype none

package sop_pkg;

  localparam int unsigned CfgW       = 11;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned OrdW       = 21;
  localparam int unsigned PosW       = 11;
  localparam int unsigned MaxSideDef = 1024;

  typedef enum logic [CfgIdxW-1:0] {
    RegColumns = 1'b0,
    RegRows    = 1'b1
  } reg_idx_e;

endpackage

`default_nettype wire

/* src/sop_if.sv */
// request and result channel interfaces for the spiral order position block
// depends on sop_pkg
`default_nettype none

interface sop_req_if;
  logic                        valid;
  logic                        ready;
  logic [sop_pkg::OrdW-1:0]    ordinal;

  modport source (output valid, output ordinal, input ready);
  modport sink   (input valid, input ordinal, output ready);
endinterface

interface sop_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [sop_pkg::PosW-1:0]    col_pos;
  logic [sop_pkg::PosW-1:0]    row_pos;

  modport source (output valid, output found, output col_pos, output row_pos, input ready);
  modport sink   (input valid, input found, input col_pos, input row_pos, output ready);
endinterface

`default_nettype wire

/* src/sop_cfg.sv */
// grid extent registers with saturation to the largest supported side
// depends on sop_pkg
`default_nettype none

module sop_cfg #(
  parameter int unsigned MAX_SIDE = sop_pkg::MaxSideDef,
  parameter int unsigned SideW    = $clog2(MAX_SIDE + 1)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [sop_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [sop_pkg::CfgW-1:0]     cfg_data_i,
  output      logic [SideW-1:0]             cols_o,
  output      logic [SideW-1:0]             rows_o
);

  localparam int unsigned ExtW = (SideW > sop_pkg::CfgW) ? SideW : sop_pkg::CfgW;

  logic [sop_pkg::CfgW-1:0] columns_q;
  logic [sop_pkg::CfgW-1:0] rows_q;
  logic [ExtW-1:0]          col_ext;
  logic [ExtW-1:0]          row_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= sop_pkg::CfgW'(1);
      rows_q    <= sop_pkg::CfgW'(1);
    end else if (cfg_we_i) begin
      unique case (sop_pkg::reg_idx_e'(cfg_idx_i))
        sop_pkg::RegColumns: columns_q <= cfg_data_i;
        sop_pkg::RegRows:    rows_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp to the largest side the datapath holds
  always_comb begin
    col_ext = ExtW'(columns_q);
    row_ext = ExtW'(rows_q);
    cols_o  = (col_ext > ExtW'(MAX_SIDE)) ? SideW'(MAX_SIDE) : SideW'(col_ext);
    rows_o  = (row_ext > ExtW'(MAX_SIDE)) ? SideW'(MAX_SIDE) : SideW'(row_ext);
  end

endmodule

`default_nettype wire

/* src/sop_cmp_sub.sv */
// shared compare and subtract unit used by the check, peel and side steps of the sequencer
// no dependencies
`default_nettype none

module sop_cmp_sub #(
  parameter int unsigned W = 22
) (
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  output      logic         lt_o,
  output      logic [W-1:0] diff_o
);

  logic [W:0] wide;

  // borrow out of a - b marks a < b
  always_comb begin
    wide   = {1'b0, a_i} - {1'b0, b_i};
    lt_o   = wide[W];
    diff_o = wide[W-1:0];
  end

endmodule

`default_nettype wire

/* src/spiral_order_position.sv */
// Spiral order position: returns the 1-based column and row of the k-th cell of a spiral
// that runs down the first column, along the last row, up the last column and back along
// the first row of the configured grid. One request is worked at a time through a single
// compare-subtract unit: a step to take it, one for the cell count, one range check, one
// step per whole ring peeled plus one that finds the ring, one to four side steps and one
// to hand over the result; a miss goes from the range check to the hand over. The
// ring-peeling loop dominates the run time. A finished result waits in an output register
// while the next request is taken; the hand over holds while an earlier result still waits.
// Depends on sop_pkg, sop_if, sop_cfg, sop_cmp_sub.
`default_nettype none

module spiral_order_position #(
  parameter int unsigned MAX_SIDE = sop_pkg::MaxSideDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [sop_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [sop_pkg::CfgW-1:0]     cfg_data_i,
  sop_req_if.sink                           ord_req_i,
  sop_rsp_if.source                         pos_rsp_o
);

  localparam int unsigned SideW = $clog2(MAX_SIDE + 1);
  localparam int unsigned RemW  = 2 * SideW;
  localparam int unsigned UW    = (RemW > sop_pkg::OrdW) ? RemW : sop_pkg::OrdW;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StCheck,
    StPeel,
    StSide,
    StDone
  } state_e;

  state_e                    state_q, state_d;
  logic                      out_valid_q, out_valid_d;
  logic                      hit_q, hit_d;
  logic [sop_pkg::OrdW-1:0]  k_q, k_d;
  logic [RemW-1:0]           total_q, total_d;
  logic [RemW-1:0]           rem_q, rem_d;
  logic [SideW-1:0]          d_q, d_d;
  logic [SideW-1:0]          w_q, w_d;
  logic [SideW-1:0]          h_q, h_d;
  logic [1:0]                side_q, side_d;
  logic                      found_q, found_d;
  logic [sop_pkg::PosW-1:0]  col_q, col_d;
  logic [sop_pkg::PosW-1:0]  row_q, row_d;

  logic [SideW-1:0]          cols;
  logic [SideW-1:0]          rows;
  logic [UW-1:0]             op_a, op_b, diff;
  logic                      lt;
  logic [UW-1:0]             per;
  logic [UW-1:0]             side_len;
  logic [SideW-1:0]          rs;
  logic [SideW-1:0]          col_s, row_s;
  logic                      load_out;

  sop_cfg #(
    .MAX_SIDE (MAX_SIDE),
    .SideW    (SideW)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cols_o     (cols),
    .rows_o     (rows)
  );

  sop_cmp_sub #(
    .W (UW)
  ) u_unit (
    .a_i    (op_a),
    .b_i    (op_b),
    .lt_o   (lt),
    .diff_o (diff)
  );

  // cells on the current ring and length of the current side
  always_comb begin
    if (w_q == SideW'(1)) begin
      per = UW'(h_q);
    end else if (h_q == SideW'(1)) begin
      per = UW'(w_q);
    end else begin
      per = ((UW'(w_q) + UW'(h_q)) << 1) - UW'(4);
    end
    case (side_q)
      2'd0:    side_len = UW'(h_q);
      2'd1:    side_len = UW'(w_q) - UW'(1);
      2'd2:    side_len = UW'(h_q) - UW'(1);
      default: side_len = UW'(h_q);
    endcase
  end

  always_comb begin
    unique case (state_q)
      StCheck: begin
        op_a = UW'(total_q);
        op_b = UW'(k_q);
      end
      StPeel: begin
        op_a = UW'(rem_q);
        op_b = per;
      end
      StSide: begin
        op_a = UW'(rem_q);
        op_b = side_len;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // 1-based cell position from ring depth, side and offset on the side
  always_comb begin
    rs = rem_q[SideW-1:0];
    case (side_q)
      2'd0: begin
        col_s = d_q + SideW'(1);
        row_s = d_q + rs + SideW'(1);
      end
      2'd1: begin
        col_s = d_q + rs + SideW'(2);
        row_s = d_q + h_q;
      end
      2'd2: begin
        col_s = d_q + w_q;
        row_s = d_q + h_q - SideW'(1) - rs;
      end
      default: begin
        col_s = d_q + w_q - SideW'(1) - rs;
        row_s = d_q + SideW'(1);
      end
    endcase
  end

  assign load_out = (state_q == StDone) && (!out_valid_q || pos_rsp_o.ready);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    hit_d       = hit_q;
    k_d         = k_q;
    total_d     = total_q;
    rem_d       = rem_q;
    d_d         = d_q;
    w_d         = w_q;
    h_d         = h_q;
    side_d      = side_q;
    found_d     = found_q;
    col_d       = col_q;
    row_d       = row_q;

    if (out_valid_q && pos_rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (ord_req_i.valid) begin
          k_d     = ord_req_i.ordinal;
          state_d = StMul;
        end
      end
      StMul: begin
        total_d = RemW'(cols) * RemW'(rows);
        state_d = StCheck;
      end
      StCheck: begin
        if ((k_q == '0) || lt) begin
          hit_d   = 1'b0;
          state_d = StDone;
        end else begin
          rem_d   = RemW'(k_q - sop_pkg::OrdW'(1));
          d_d     = '0;
          w_d     = cols;
          h_d     = rows;
          state_d = StPeel;
        end
      end
      StPeel: begin
        if (lt) begin
          side_d  = 2'd0;
          state_d = StSide;
        end else begin
          rem_d = diff[RemW-1:0];
          d_d   = d_q + SideW'(1);
          w_d   = w_q - SideW'(2);
          h_d   = h_q - SideW'(2);
        end
      end
      StSide: begin
        if ((side_q == 2'd3) || lt) begin
          hit_d   = 1'b1;
          state_d = StDone;
        end else begin
          rem_d  = diff[RemW-1:0];
          side_d = side_q + 2'd1;
        end
      end
      StDone: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          found_d     = hit_q;
          col_d       = hit_q ? sop_pkg::PosW'(col_s) : '0;
          row_d       = hit_q ? sop_pkg::PosW'(row_s) : '0;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q   <= hit_d;
    k_q     <= k_d;
    total_q <= total_d;
    rem_q   <= rem_d;
    d_q     <= d_d;
    w_q     <= w_d;
    h_q     <= h_d;
    side_q  <= side_d;
    found_q <= found_d;
    col_q   <= col_d;
    row_q   <= row_d;
  end

  assign ord_req_i.ready   = (state_q == StIdle);
  assign pos_rsp_o.valid   = out_valid_q;
  assign pos_rsp_o.found   = found_q;
  assign pos_rsp_o.col_pos = col_q;
  assign pos_rsp_o.row_pos = row_q;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_rsp_o.valid && !pos_rsp_o.found) |-> (pos_rsp_o.col_pos == '0 && pos_rsp_o.row_pos == '0))
    else $error("miss result carries a position");

  a_hit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_rsp_o.valid && pos_rsp_o.found) |-> (pos_rsp_o.col_pos != '0 && pos_rsp_o.row_pos != '0))
    else $error("hit result has a zero coordinate");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ord_req_i.valid && ord_req_i.ready) |=> !ord_req_i.ready)
    else $error("request taken while busy");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPeel) |-> (d_q <= SideW'(MAX_SIDE / 2)))
    else $error("ring depth beyond half the side");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pos_rsp_o.ready) |=> (out_valid_q && $stable(col_q) && $stable(row_q)))
    else $error("waiting result overwritten");

endmodule

`default_nettype wire
